/* design/urx_pkg.sv */
package urx_pkg;

    localparam int RING_DEPTH   = 256;
    localparam int POS_W        = $clog2(RING_DEPTH);
    localparam int SIZE_W       = $clog2(RING_DEPTH + 1);
    localparam int MIN_RING     = 2;
    localparam int NUM_COUNTERS = 9;
    localparam int NUM_FLAGS    = 5;
    localparam int CNT_W        = 32;
    localparam int BURST_W      = 16;

    localparam int CNT_SERVICES  = 0;
    localparam int CNT_BYTES     = 1;
    localparam int CNT_OVERRUN   = 2;
    localparam int CNT_RING_OVF  = 7;
    localparam int CNT_MAX_BURST = 8;

    localparam logic RC_OK    = 1'b0;
    localparam logic RC_EMPTY = 1'b1;

    typedef enum logic [2:0] {
        OP_BYTE      = 3'd0,
        OP_BURST_END = 3'd1,
        OP_READ      = 3'd2,
        OP_FLUSH     = 3'd3,
        OP_READ_CNT  = 3'd4,
        OP_CLEAR     = 3'd5
    } t_op;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

/* design/uart_rx_ring_with_error_counters.sv */
// UART receive ring with error and burst statistics.
//
// Request channel: i_in_valid / o_in_stall carrying operation, data_byte,
// claimed_by_transfer, error_flags and counter_index. Result channel:
// o_out_valid / i_out_stall, one result per request, held in an output
// register; a new request is taken in the cycle the previous result is taken.
// Config channel: i_cfg_valid / o_cfg_ready writes ring_size (clamped to
// 2..256); a write empties the ring, clears counters and burst state.
//
// Results: o_out_valid is driven from a register; a read of a non-empty
// ring first passes through S_READ, because the ring RAM read data is
// registered. Throughput: 1 request per cycle while o_in_stall is low; a
// read that pops a byte holds off the next request until its data returns.
//
// Reset (synchronous, i_rst_n low): ring empty, counters zero, size 256.
// Ring RAM contents are not cleared; only written slots are read back.
// When the receiver stalls with a result pending, o_in_stall rises and
// holds off further requests until the result is taken.
module uart_rx_ring_with_error_counters
    import urx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [SIZE_W-1:0]    i_cfg_ring_size,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_operation,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_claimed_by_transfer,
    input  logic [NUM_FLAGS-1:0] i_error_flags,
    input  logic [3:0]           i_counter_index,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_read_data,
    output logic                 o_result_code,
    output logic                 o_byte_available,
    output logic [4:0]           o_event_bits,
    output logic [CNT_W-1:0]     o_counter_value
);

    t_state               r_state, n_state;
    logic [SIZE_W-1:0]    r_ring_size, n_ring_size;
    logic [POS_W-1:0]     r_rd_pos, n_rd_pos;
    logic [POS_W-1:0]     r_wr_pos, n_wr_pos;
    logic [BURST_W-1:0]   r_burst_cnt, n_burst_cnt;
    logic                 r_burst_stored, n_burst_stored;
    logic                 r_burst_dropped, n_burst_dropped;
    logic [CNT_W-1:0]     r_cnt [NUM_COUNTERS];
    logic [CNT_W-1:0]     n_cnt [NUM_COUNTERS];

    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_read_data, n_read_data;
    logic                 r_result_code, n_result_code;
    logic                 r_byte_avail, n_byte_avail;
    logic [4:0]           r_events, n_events;
    logic [CNT_W-1:0]     r_cnt_value, n_cnt_value;

    logic                 accept;
    logic                 cfg_wr;
    logic                 out_take;
    logic [SIZE_W-1:0]    wr_inc;
    logic [SIZE_W-1:0]    rd_inc;
    logic [POS_W-1:0]     wr_next;
    logic [POS_W-1:0]     rd_next;
    logic                 ring_full;
    logic                 ring_empty;
    logic                 ram_we;
    logic                 ram_re;
    logic [7:0]           ram_rdata;
    t_op                  op;

    assign o_cfg_ready = (r_state == S_IDLE);
    // a pending config write holds off requests so the two never share an edge
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall) || i_cfg_valid;
    assign accept      = i_in_valid && !o_in_stall;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign out_take    = r_out_valid && !i_out_stall;
    assign op          = t_op'(i_operation);

    // wrap positions at the configured size
    assign wr_inc     = SIZE_W'(r_wr_pos) + SIZE_W'(1);
    assign rd_inc     = SIZE_W'(r_rd_pos) + SIZE_W'(1);
    assign wr_next    = (wr_inc >= r_ring_size) ? '0 : wr_inc[POS_W-1:0];
    assign rd_next    = (rd_inc >= r_ring_size) ? '0 : rd_inc[POS_W-1:0];
    assign ring_full  = (wr_next == r_rd_pos);
    assign ring_empty = (r_rd_pos == r_wr_pos);

    assign ram_we = accept && !cfg_wr && (op == OP_BYTE) && !i_claimed_by_transfer
                    && !ring_full;
    assign ram_re = accept && !cfg_wr && (op == OP_READ) && !ring_empty;

    urx_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_pos),
        .i_wdata (i_data_byte),
        .i_re    (ram_re),
        .i_raddr (r_rd_pos),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_ring_size     = r_ring_size;
        n_rd_pos        = r_rd_pos;
        n_wr_pos        = r_wr_pos;
        n_burst_cnt     = r_burst_cnt;
        n_burst_stored  = r_burst_stored;
        n_burst_dropped = r_burst_dropped;
        n_cnt           = r_cnt;
        n_out_valid     = r_out_valid && !out_take;
        n_read_data     = r_read_data;
        n_result_code   = r_result_code;
        n_byte_avail    = r_byte_avail;
        n_events        = r_events;
        n_cnt_value     = r_cnt_value;

        unique case (r_state)
            S_IDLE: begin
                if (cfg_wr) begin
                    if (i_cfg_ring_size < SIZE_W'(MIN_RING)) begin
                        n_ring_size = SIZE_W'(MIN_RING);
                    end else if (i_cfg_ring_size > SIZE_W'(RING_DEPTH)) begin
                        n_ring_size = SIZE_W'(RING_DEPTH);
                    end else begin
                        n_ring_size = i_cfg_ring_size;
                    end
                    n_rd_pos        = '0;
                    n_wr_pos        = '0;
                    n_burst_cnt     = '0;
                    n_burst_stored  = 1'b0;
                    n_burst_dropped = 1'b0;
                    for (int k = 0; k < NUM_COUNTERS; k++) begin
                        n_cnt[k] = '0;
                    end
                end else if (accept) begin
                    n_read_data   = '0;
                    n_result_code = RC_OK;
                    n_events      = '0;
                    n_cnt_value   = '0;
                    n_out_valid   = 1'b1;
                    case (op)
                        OP_BYTE: begin
                            if (r_burst_cnt != '1) begin
                                n_burst_cnt = r_burst_cnt + BURST_W'(1);
                            end
                            if (!i_claimed_by_transfer) begin
                                n_burst_stored = 1'b1;
                                if (ring_full) begin
                                    n_cnt[CNT_RING_OVF] = r_cnt[CNT_RING_OVF] + CNT_W'(1);
                                    n_burst_dropped     = 1'b1;
                                end else begin
                                    n_wr_pos = wr_next;
                                end
                            end
                        end
                        OP_BURST_END: begin
                            n_cnt[CNT_SERVICES] = r_cnt[CNT_SERVICES] + CNT_W'(1);
                            n_cnt[CNT_BYTES]    = r_cnt[CNT_BYTES] + CNT_W'(r_burst_cnt);
                            if (CNT_W'(r_burst_cnt) > r_cnt[CNT_MAX_BURST]) begin
                                n_cnt[CNT_MAX_BURST] = CNT_W'(r_burst_cnt);
                            end
                            for (int k = 0; k < NUM_FLAGS; k++) begin
                                if (i_error_flags[k]) begin
                                    n_cnt[CNT_OVERRUN+k] = r_cnt[CNT_OVERRUN+k] + CNT_W'(1);
                                end
                            end
                            n_events        = {r_burst_stored, r_burst_dropped,
                                               i_error_flags[2:0]};
                            n_burst_cnt     = '0;
                            n_burst_stored  = 1'b0;
                            n_burst_dropped = 1'b0;
                        end
                        OP_READ: begin
                            if (ring_empty) begin
                                n_result_code = RC_EMPTY;
                            end else begin
                                // data comes back from the RAM next cycle
                                n_rd_pos    = rd_next;
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        OP_FLUSH: begin
                            n_rd_pos = r_wr_pos;
                        end
                        OP_READ_CNT: begin
                            if (i_counter_index < 4'(NUM_COUNTERS)) begin
                                n_cnt_value = r_cnt[i_counter_index];
                            end
                        end
                        OP_CLEAR: begin
                            for (int k = 0; k < NUM_COUNTERS; k++) begin
                                n_cnt[k] = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_byte_avail = (n_rd_pos != n_wr_pos);
                end
            end
            S_READ: begin
                n_out_valid  = 1'b1;
                n_read_data  = ram_rdata;
                n_byte_avail = !ring_empty;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size     <= SIZE_W'(RING_DEPTH);
            r_rd_pos        <= '0;
            r_wr_pos        <= '0;
            r_burst_cnt     <= '0;
            r_burst_stored  <= 1'b0;
            r_burst_dropped <= 1'b0;
            r_out_valid     <= 1'b0;
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_ring_size     <= n_ring_size;
            r_rd_pos        <= n_rd_pos;
            r_wr_pos        <= n_wr_pos;
            r_burst_cnt     <= n_burst_cnt;
            r_burst_stored  <= n_burst_stored;
            r_burst_dropped <= n_burst_dropped;
            r_out_valid     <= n_out_valid;
            r_cnt           <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_data   <= n_read_data;
        r_result_code <= n_result_code;
        r_byte_avail  <= n_byte_avail;
        r_events      <= n_events;
        r_cnt_value   <= n_cnt_value;
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_read_data;
    assign o_result_code    = r_result_code;
    assign o_byte_available = r_byte_avail;
    assign o_event_bits     = r_events;
    assign o_counter_value  = r_cnt_value;

    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_state == S_IDLE)
        else $error("ring read wait lasted more than one cycle");

    a_read_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !r_out_valid)
        else $error("output register busy while ring read data returns");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SIZE_W'(r_rd_pos) < r_ring_size) && (SIZE_W'(r_wr_pos) < r_ring_size))
        else $error("ring position beyond configured size");

    a_empty_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_result_code == RC_EMPTY) |-> (r_read_data == '0))
        else $error("empty read returned data");

    a_max_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[CNT_MAX_BURST][CNT_W-1:BURST_W] == '0)
        else $error("max burst counter exceeds burst count range");

endmodule

/* design/urx_ram.sv */
module urx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* verif/tb_uart_rx_ring_with_error_counters.sv */
module tb_uart_rx_ring_with_error_counters;
    import urx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          LONG_BURST  = 280;
    localparam logic [2:0]  OP_UNUSED6  = 3'd6;
    localparam logic [2:0]  OP_UNUSED7  = 3'd7;
    localparam logic [3:0]  CNT_IDX_TOP = 4'd15;
    localparam logic [15:0] BURST_SAT   = 16'hFFFF;

    typedef struct packed {
        logic [2:0]           op;
        logic [7:0]           data;
        logic                 claimed;
        logic [NUM_FLAGS-1:0] flags;
        logic [3:0]           idx;
    } rx_req_t;

    typedef struct packed {
        logic [7:0]       rdata;
        logic             code;
        logic             avail;
        logic [4:0]       events;
        logic [CNT_W-1:0] cval;
    } rx_rsp_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [SIZE_W-1:0]    i_cfg_ring_size = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [2:0]           i_operation = '0;
    logic [7:0]           i_data_byte = '0;
    logic                 i_claimed_by_transfer = 1'b0;
    logic [NUM_FLAGS-1:0] i_error_flags = '0;
    logic [3:0]           i_counter_index = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [7:0]           o_read_data;
    logic                 o_result_code;
    logic                 o_byte_available;
    logic [4:0]           o_event_bits;
    logic [CNT_W-1:0]     o_counter_value;

    uart_rx_ring_with_error_counters dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_ring_size       (i_cfg_ring_size),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_operation           (i_operation),
        .i_data_byte           (i_data_byte),
        .i_claimed_by_transfer (i_claimed_by_transfer),
        .i_error_flags         (i_error_flags),
        .i_counter_index       (i_counter_index),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_read_data           (o_read_data),
        .o_result_code         (o_result_code),
        .o_byte_available      (o_byte_available),
        .o_event_bits          (o_event_bits),
        .o_counter_value       (o_counter_value)
    );

    // predicted block state
    logic [7:0]       ring_mem [RING_DEPTH];
    int               rd_pos;
    int               wr_pos;
    int               ring_size;
    logic [15:0]      burst_len;
    logic             burst_stored;
    logic             burst_dropped;
    logic [CNT_W-1:0] counters [NUM_COUNTERS];

    rx_req_t queued_requests [$];
    rx_rsp_t due_results [$];
    rx_req_t cur_req;
    int      pushed;
    int      mismatches;
    int      cycles;
    int      gap_left;
    int      stall_left;
    logic    idle_en;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void clear_state();
        rd_pos        = 0;
        wr_pos        = 0;
        burst_len     = '0;
        burst_stored  = 1'b0;
        burst_dropped = 1'b0;
        foreach (counters[i]) counters[i] = '0;
    endfunction

    function automatic int next_slot(input int pos);
        return (pos + 1 >= ring_size) ? 0 : pos + 1;
    endfunction

    function automatic void ring_step(input rx_req_t rq);
        rx_rsp_t rs;
        int      nxt;
        rs = '0;
        case (rq.op)
            OP_BYTE: begin
                if (burst_len != BURST_SAT) burst_len++;
                if (!rq.claimed) begin
                    nxt = next_slot(wr_pos);
                    if (nxt == rd_pos) begin
                        counters[CNT_RING_OVF]++;
                        burst_dropped = 1'b1;
                    end else begin
                        ring_mem[wr_pos] = rq.data;
                        wr_pos = nxt;
                    end
                    // set even when the byte was dropped
                    burst_stored = 1'b1;
                end
            end
            OP_BURST_END: begin
                counters[CNT_SERVICES]++;
                counters[CNT_BYTES] += CNT_W'(burst_len);
                if (CNT_W'(burst_len) > counters[CNT_MAX_BURST])
                    counters[CNT_MAX_BURST] = CNT_W'(burst_len);
                for (int f = 0; f < NUM_FLAGS; f++)
                    if (rq.flags[f]) counters[CNT_OVERRUN + f]++;
                rs.events     = {burst_stored, burst_dropped, rq.flags[2:0]};
                burst_len     = '0;
                burst_stored  = 1'b0;
                burst_dropped = 1'b0;
            end
            OP_READ: begin
                if (rd_pos == wr_pos) begin
                    rs.code = RC_EMPTY;
                end else begin
                    rs.rdata = ring_mem[rd_pos];
                    rd_pos   = next_slot(rd_pos);
                end
            end
            OP_FLUSH: rd_pos = wr_pos;
            OP_READ_CNT: begin
                if (rq.idx < NUM_COUNTERS) rs.cval = counters[rq.idx];
            end
            OP_CLEAR: begin
                foreach (counters[i]) counters[i] = '0;
            end
            default: ;
        endcase
        rs.avail = (rd_pos != wr_pos);
        due_results.push_back(rs);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && !o_in_stall) ring_step(cur_req);
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    cur_req = queued_requests.pop_front();
                    i_in_valid            <= 1'b1;
                    i_operation           <= cur_req.op;
                    i_data_byte           <= cur_req.data;
                    i_claimed_by_transfer <= cur_req.claimed;
                    i_error_flags         <= cur_req.flags;
                    i_counter_index       <= cur_req.idx;
                    gap_left = (idle_en && $urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        rx_rsp_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result with no request outstanding");
                end else begin
                    want = due_results.pop_front();
                    check_field("read_data", want.rdata, o_read_data);
                    check_field("result_code", want.code, o_result_code);
                    check_field("byte_available", want.avail, o_byte_available);
                    check_field("event_bits", want.events, o_event_bits);
                    check_field("counter_value", want.cval, o_counter_value);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 10);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_req(input logic [2:0] op, input logic [7:0] d, input logic c,
                            input logic [NUM_FLAGS-1:0] f, input logic [3:0] x);
        rx_req_t rq;
        rq.op      = op;
        rq.data    = d;
        rq.claimed = c;
        rq.flags   = f;
        rq.idx     = x;
        queued_requests.push_back(rq);
        pushed++;
    endtask

    task automatic push_noise(input logic [2:0] op);
        push_req(op, 8'($urandom), 1'($urandom), 5'($urandom), 4'($urandom));
    endtask

    // mostly bursts followed by reads, some loose random requests
    task automatic gen_traffic(input int n);
        int goal;
        int len;
        int k;
        goal = pushed + n;
        while (pushed < goal) begin
            if ($urandom_range(0, 4) == 0) begin
                push_noise(3'($urandom_range(0, 7)));
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, ring_size + 3)
                                                  : $urandom_range(1, 8);
                // keep the request count near the goal
                if (len > (goal - pushed) / 2) len = (goal - pushed) / 2 + 1;
                repeat (len)
                    push_req(OP_BYTE, 8'($urandom), $urandom_range(0, 3) == 0,
                             5'($urandom), 4'($urandom));
                push_noise(OP_BURST_END);
                k = $urandom_range(0, len + 2);
                repeat (k) push_noise(OP_READ);
                if ($urandom_range(0, 2) == 0) push_noise(OP_READ_CNT);
                if ($urandom_range(0, 15) == 0) push_noise(OP_FLUSH);
                if ($urandom_range(0, 19) == 0) push_noise(OP_CLEAR);
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (queued_requests.size() != 0 || i_in_valid || due_results.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_ring_size(input int value);
        logic [SIZE_W-1:0] v;
        v = SIZE_W'(value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_ring_size <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ring_size = (v < MIN_RING) ? MIN_RING : (v > RING_DEPTH) ? RING_DEPTH : int'(v);
        clear_state();
        @(negedge i_clk);
    endtask

    initial begin
        ring_size  = RING_DEPTH;
        pushed     = 0;
        mismatches = 0;
        cycles     = 0;
        idle_en    = 1'b1;
        clear_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty read, byte extremes, claimed byte, all flags, counters
        push_req(OP_READ, 8'h00, 1'b0, 5'h00, 4'h0);
        push_req(OP_BYTE, 8'h00, 1'b0, 5'h00, 4'h0);
        push_req(OP_BYTE, 8'hFF, 1'b0, 5'h1F, 4'hF);
        push_req(OP_BYTE, 8'hA5, 1'b1, 5'h00, 4'h0);
        push_req(OP_BURST_END, 8'h00, 1'b0, 5'h1F, 4'h0);
        push_req(OP_BURST_END, 8'hFF, 1'b1, 5'h00, 4'h0);
        push_req(OP_READ, 8'hFF, 1'b1, 5'h1F, 4'hF);
        push_req(OP_READ, 8'h00, 1'b0, 5'h00, 4'h0);
        push_req(OP_READ, 8'h00, 1'b0, 5'h00, 4'h0);
        push_req(OP_BYTE, 8'h5A, 1'b0, 5'h00, 4'h0);
        push_req(OP_FLUSH, 8'h00, 1'b0, 5'h00, 4'h0);
        push_req(OP_READ, 8'h00, 1'b0, 5'h00, 4'h0);
        for (int i = 0; i < NUM_COUNTERS; i++)
            push_req(OP_READ_CNT, 8'h00, 1'b0, 5'h00, 4'(i));
        push_req(OP_READ_CNT, 8'h00, 1'b0, 5'h00, 4'(NUM_COUNTERS));
        push_req(OP_READ_CNT, 8'h00, 1'b0, 5'h00, CNT_IDX_TOP);
        push_noise(OP_UNUSED6);
        push_noise(OP_UNUSED7);
        push_req(OP_CLEAR, 8'h00, 1'b0, 5'h00, 4'h0);
        push_req(OP_READ_CNT, 8'h00, 1'b0, 5'h00, 4'(CNT_SERVICES));

        write_ring_size(MIN_RING);
        gen_traffic(120);
        // below minimum, clamps up
        write_ring_size(0);
        gen_traffic(80);
        // above depth, clamps down
        write_ring_size(511);
        gen_traffic(140);
        write_ring_size(3);
        gen_traffic(100);

        // one long burst that overruns the full-size ring, run without idling
        write_ring_size(RING_DEPTH + 1);
        idle_en = 1'b0;
        repeat (LONG_BURST)
            push_req(OP_BYTE, 8'($urandom), 1'b0, 5'($urandom), 4'($urandom));
        push_noise(OP_BURST_END);
        for (int i = 0; i < NUM_COUNTERS; i++)
            push_req(OP_READ_CNT, 8'($urandom), 1'($urandom), 5'($urandom), 4'(i));
        repeat (20) push_noise(OP_READ);
        wait_idle();
        idle_en = 1'b1;

        write_ring_size($urandom_range(4, RING_DEPTH - 1));
        gen_traffic(150);
        write_ring_size(1);
        gen_traffic(80);
        write_ring_size(RING_DEPTH);
        idle_en = 1'b0;
        gen_traffic(140);

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* uart_rx_ring_with_error_counters.f */
design/urx_pkg.sv
design/urx_ram.sv
design/uart_rx_ring_with_error_counters.sv
verif/tb_uart_rx_ring_with_error_counters.sv
